// File: rtl/core/cppb_pkg.sv
// Shared types and constants for the controller port packet builder.
// Depends on nothing; used by the top level and the aim unit.
package cppb_pkg;

    // Width of the lightgun aim value (frame bit 16 down to bit 0).
    localparam int AIM_W = 17;

    // Width of a position coordinate as it arrives on the input stream.
    localparam int POS_W = 16;

    // Stage strobes from the sequencer to the aim unit, one per microcode step.
    typedef struct packed {
        logic scale;   // scale coordinates to 640 by 240
        logic sum;     // weighted sum of the scaled coordinates
        logic mul;     // reciprocal multiply for the divide by 625
        logic fix;     // quotient correction
    } t_aim_ctl;

endpackage

// File: rtl/core/cppb_aim.sv
// Lightgun aim unit: fixed-point r = floor((y'*794386 + x'*1000) / 5000).
// Four register stages, each strobed by the sequencer. Depends on cppb_pkg.
module cppb_aim (
    input  logic                                i_clk,
    input  cppb_pkg::t_aim_ctl                  i_ctl,
    input  logic signed [cppb_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [cppb_pkg::POS_W-1:0]   i_pos_y,
    input  logic                                i_away,
    output logic        [cppb_pkg::AIM_W-1:0]   o_aim
);
    import cppb_pkg::*;

    // Reciprocal of 625 scaled by 2^32, rounded down.
    localparam logic [22:0] RECIP_625 = 23'd6871947;

    logic [15:0] ux;
    logic [15:0] uy;
    logic [25:0] vx;
    logic [23:0] vy;
    logic [9:0]  qx0;
    logic [7:0]  qy0;
    logic [16:0] sx;
    logic [16:0] sy;
    logic [9:0]  n_xs;
    logic [7:0]  n_ys;
    logic [27:0] wsum;
    logic [15:0] q;
    logic [25:0] qm;
    logic [24:0] rem;

    logic [9:0]  r_xs;
    logic [7:0]  r_ys;
    logic [24:0] r_w;
    logic [47:0] r_p;
    logic [AIM_W-1:0] r_aim;

    // Offset binary coordinates times 640 and 240, then floor divide by 65535 (away gives 320 and 0).
    // v / 65535 is (v >> 16) plus one when the folded remainder reaches 65535.
    always_comb begin
        ux   = {~i_pos_x[15], i_pos_x[14:0]};
        uy   = {~i_pos_y[15], i_pos_y[14:0]};
        vx   = 26'({ux, 9'd0}) + 26'({ux, 7'd0});
        vy   = 24'({uy, 8'd0}) - 24'({uy, 4'd0});
        qx0  = vx[25:16];
        qy0  = vy[23:16];
        sx   = 17'(vx[15:0]) + 17'(qx0);
        sy   = 17'(vy[15:0]) + 17'(qy0);
        n_xs = (sx >= 17'd65535) ? qx0 + 10'd1 : qx0;
        n_ys = (sy >= 17'd65535) ? qy0 + 8'd1 : qy0;
        if (i_away) begin
            n_xs = 10'd320;
            n_ys = 8'd0;
        end
    end

    // Weighted sum; x' * 1000 is built from shifts.
    always_comb begin
        wsum = 28'(r_ys) * 28'd794386
             + 28'({r_xs, 10'd0}) - 28'({r_xs, 4'd0}) - 28'({r_xs, 3'd0});
    end

    // Quotient estimate is low by at most one; fix it from the remainder.
    always_comb begin
        q   = r_p[47:32];
        qm  = 26'({q, 9'd0}) + 26'({q, 6'd0}) + 26'({q, 5'd0})
            + 26'({q, 4'd0}) + 26'(q);
        rem = r_w - qm[24:0];
    end

    // Stage registers.
    always_ff @(posedge i_clk) begin
        if (i_ctl.scale) begin
            r_xs <= n_xs;
            r_ys <= n_ys;
        end
        if (i_ctl.sum) begin
            r_w <= wsum[27:3];
        end
        if (i_ctl.mul) begin
            r_p <= 48'(r_w) * 48'(RECIP_625);
        end
        if (i_ctl.fix) begin
            r_aim <= (rem >= 25'd625) ? AIM_W'(q) + AIM_W'(1) : AIM_W'(q);
        end
    end

    assign o_aim = r_aim;

endmodule

// File: rtl/core/controller_port_packet_builder_unit.sv
// Top level of the controller port packet builder: microcoded sequencer and byte datapath.
// Depends on cppb_pkg and the aim unit cppb_aim.
//
//  Channel   Direction  Handshake                 Payload
//  s (in)    input      i_s_tvalid / o_s_tready   tuser: req_type; tdata: report fields
//  m (out)   output     o_m_tvalid / i_m_tready   tdata: frame byte, position; tlast
//
// An item is accepted in the idle state, then one microcode step runs per cycle unless the
// output stalls: a length check (not for pad or reset), one step per frame byte and four aim
// steps for lightguns. Frame bytes leave through a single output register.
// Reset (synchronous, active low) zeroes the write position and empties the output.
// A stall on the output holds the sequencer on its current byte step.
module controller_port_packet_builder_unit #(
    parameter int BUFFER_BYTES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [11:0] buttons, [27:12] pos_x, [43:28] pos_y, [59:44] pos_z, [60] away_flag
    input  logic [63:0] i_s_tdata,
    // [2:0] req_type
    input  logic [2:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] frame_byte, [15:8] byte_position
    output logic [15:0] o_m_tdata,
    output logic        o_m_tlast
);
    import cppb_pkg::*;

    typedef enum logic [2:0] {
        REQ_JOYPAD, REQ_FLIGHT, REQ_MOUSE, REQ_LIGHTGUN,
        REQ_ARCADE, REQ_TRACKBALL, REQ_PAD, REQ_RESET
    } t_req;

    typedef enum logic [2:0] {
        K_HALT, K_CHECK, K_AIM, K_EMIT, K_PAD, K_CLEAR
    } t_kind;

    typedef enum logic [4:0] {
        B_IMM, B_JP0, B_JP1, B_FS3, B_FS4, B_FS5, B_FS6, B_FS7, B_FS8,
        B_MS1, B_TB1, B_XY2, B_X3, B_TB6, B_LG1, B_LG2, B_LG3
    } t_bsel;

    typedef enum logic [1:0] {
        AS_SCALE, AS_SUM, AS_MUL, AS_FIX
    } t_astage;

    typedef struct packed {
        t_kind      kind;
        t_bsel      sel;
        logic [7:0] imm;
        logic [3:0] len;
        t_astage    stage;
        logic       last;
    } t_uword;

    typedef enum logic {
        ST_IDLE, ST_RUN
    } t_state;

    localparam int STEP_W = 6;

    function automatic t_uword mk(t_kind k, t_bsel s, logic [7:0] imm, logic [3:0] len,
                                  t_astage st, logic last);
        t_uword w;
        w.kind  = k;
        w.sel   = s;
        w.imm   = imm;
        w.len   = len;
        w.stage = st;
        w.last  = last;
        return w;
    endfunction

    // Microprogram: one control word per step.
    function automatic t_uword ucode(logic [STEP_W-1:0] a);
        t_uword w;
        case (a)
            // Joypad
            6'd0:  w = mk(K_CHECK, B_IMM, 8'h00, 4'd2, AS_SCALE, 1'b0);
            6'd1:  w = mk(K_EMIT,  B_JP0, 8'h00, 4'd0, AS_SCALE, 1'b0);
            6'd2:  w = mk(K_EMIT,  B_JP1, 8'h00, 4'd0, AS_SCALE, 1'b1);
            // Flightstick
            6'd3:  w = mk(K_CHECK, B_IMM, 8'h00, 4'd9, AS_SCALE, 1'b0);
            6'd4:  w = mk(K_EMIT,  B_IMM, 8'h01, 4'd0, AS_SCALE, 1'b0);
            6'd5:  w = mk(K_EMIT,  B_IMM, 8'h7B, 4'd0, AS_SCALE, 1'b0);
            6'd6:  w = mk(K_EMIT,  B_IMM, 8'h08, 4'd0, AS_SCALE, 1'b0);
            6'd7:  w = mk(K_EMIT,  B_FS3, 8'h00, 4'd0, AS_SCALE, 1'b0);
            6'd8:  w = mk(K_EMIT,  B_FS4, 8'h00, 4'd0, AS_SCALE, 1'b0);
            6'd9:  w = mk(K_EMIT,  B_FS5, 8'h00, 4'd0, AS_SCALE, 1'b0);
            6'd10: w = mk(K_EMIT,  B_FS6, 8'h00, 4'd0, AS_SCALE, 1'b0);
            6'd11: w = mk(K_EMIT,  B_FS7, 8'h00, 4'd0, AS_SCALE, 1'b0);
            6'd12: w = mk(K_EMIT,  B_FS8, 8'h00, 4'd0, AS_SCALE, 1'b1);
            // Mouse
            6'd13: w = mk(K_CHECK, B_IMM, 8'h00, 4'd4, AS_SCALE, 1'b0);
            6'd14: w = mk(K_EMIT,  B_IMM, 8'h49, 4'd0, AS_SCALE, 1'b0);
            6'd15: w = mk(K_EMIT,  B_MS1, 8'h00, 4'd0, AS_SCALE, 1'b0);
            6'd16: w = mk(K_EMIT,  B_XY2, 8'h00, 4'd0, AS_SCALE, 1'b0);
            6'd17: w = mk(K_EMIT,  B_X3,  8'h00, 4'd0, AS_SCALE, 1'b1);
            // Lightgun and arcade lightgun
            6'd18: w = mk(K_CHECK, B_IMM, 8'h00, 4'd4, AS_SCALE, 1'b0);
            6'd19: w = mk(K_AIM,   B_IMM, 8'h00, 4'd0, AS_SCALE, 1'b0);
            6'd20: w = mk(K_AIM,   B_IMM, 8'h00, 4'd0, AS_SUM,   1'b0);
            6'd21: w = mk(K_AIM,   B_IMM, 8'h00, 4'd0, AS_MUL,   1'b0);
            6'd22: w = mk(K_AIM,   B_IMM, 8'h00, 4'd0, AS_FIX,   1'b0);
            6'd23: w = mk(K_EMIT,  B_IMM, 8'h4D, 4'd0, AS_SCALE, 1'b0);
            6'd24: w = mk(K_EMIT,  B_LG1, 8'h00, 4'd0, AS_SCALE, 1'b0);
            6'd25: w = mk(K_EMIT,  B_LG2, 8'h00, 4'd0, AS_SCALE, 1'b0);
            6'd26: w = mk(K_EMIT,  B_LG3, 8'h00, 4'd0, AS_SCALE, 1'b1);
            // Trackball
            6'd27: w = mk(K_CHECK, B_IMM, 8'h00, 4'd8, AS_SCALE, 1'b0);
            6'd28: w = mk(K_EMIT,  B_IMM, 8'h49, 4'd0, AS_SCALE, 1'b0);
            6'd29: w = mk(K_EMIT,  B_TB1, 8'h00, 4'd0, AS_SCALE, 1'b0);
            6'd30: w = mk(K_EMIT,  B_XY2, 8'h00, 4'd0, AS_SCALE, 1'b0);
            6'd31: w = mk(K_EMIT,  B_X3,  8'h00, 4'd0, AS_SCALE, 1'b0);
            6'd32: w = mk(K_EMIT,  B_IMM, 8'hC0, 4'd0, AS_SCALE, 1'b0);
            6'd33: w = mk(K_EMIT,  B_IMM, 8'h00, 4'd0, AS_SCALE, 1'b0);
            6'd34: w = mk(K_EMIT,  B_TB6, 8'h00, 4'd0, AS_SCALE, 1'b0);
            6'd35: w = mk(K_EMIT,  B_IMM, 8'h00, 4'd0, AS_SCALE, 1'b1);
            // Pad and reset requests
            6'd36: w = mk(K_PAD,   B_IMM, 8'hFF, 4'd0, AS_SCALE, 1'b0);
            6'd37: w = mk(K_CLEAR, B_IMM, 8'h00, 4'd0, AS_SCALE, 1'b0);
            default: w = mk(K_HALT, B_IMM, 8'h00, 4'd0, AS_SCALE, 1'b0);
        endcase
        return w;
    endfunction

    // Program entry point for each request type.
    function automatic logic [STEP_W-1:0] entry(t_req t);
        logic [STEP_W-1:0] a;
        case (t)
            REQ_JOYPAD:    a = 6'd0;
            REQ_FLIGHT:    a = 6'd3;
            REQ_MOUSE:     a = 6'd13;
            REQ_LIGHTGUN:  a = 6'd18;
            REQ_ARCADE:    a = 6'd18;
            REQ_TRACKBALL: a = 6'd27;
            REQ_PAD:       a = 6'd36;
            REQ_RESET:     a = 6'd37;
            default:       a = 6'd37;
        endcase
        return a;
    endfunction

    // Control registers
    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [2:0]          r_pcnt, n_pcnt;
    logic [8:0]          r_wp, n_wp;
    logic                r_out_valid, n_out_valid;
    logic [7:0]          r_out_byte, n_out_byte;
    logic [7:0]          r_out_pos, n_out_pos;
    logic                r_out_last, n_out_last;

    // Report registers
    t_req                r_type;
    logic [11:0]         r_btn;
    logic signed [15:0]  r_pos_x;
    logic signed [15:0]  r_pos_y;
    logic signed [15:0]  r_pos_z;
    logic                r_away;

    t_uword              uw;
    t_aim_ctl            aim_ctl;
    logic [AIM_W-1:0]    aim;
    logic [7:0]          dbyte;
    logic                s_accept;
    logic                out_free;
    logic                fits;
    logic                room;
    logic                pad_last;
    logic [8:0]          wp_inc;
    logic                trig;

    assign uw         = ucode(r_step);
    assign o_s_tready = (r_state == ST_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign wp_inc     = r_wp + 9'd1;
    assign fits       = (10'(r_wp) + 10'(uw.len)) < 10'(BUFFER_BYTES);
    assign room       = 10'(r_wp) < 10'(BUFFER_BYTES);
    assign pad_last   = (r_pcnt == 3'd7) || (10'(wp_inc) >= 10'(BUFFER_BYTES));
    assign trig       = r_away | r_btn[0];

    // Frame byte selection from the report fields and the aim value.
    always_comb begin
        case (uw.sel)
            B_IMM: dbyte = uw.imm;
            B_JP0: dbyte = {3'b100, r_btn[4:0]};
            B_JP1: dbyte = {r_btn[10:5], 2'b00};
            B_FS3: dbyte = {~r_pos_x[15], r_pos_x[14:8]};
            B_FS4: dbyte = {2'b00, ~r_pos_y[15], r_pos_y[14:10]};
            B_FS5: dbyte = {r_pos_y[9:8], 2'b00, ~r_pos_z[15], r_pos_z[14:12]};
            B_FS6: dbyte = {r_pos_z[11:8], 4'h2};
            B_FS7: dbyte = r_btn[7:0];
            B_FS8: dbyte = {r_btn[11:8], 4'h0};
            B_MS1: dbyte = {r_btn[3:0], r_pos_y[9:6]};
            B_TB1: dbyte = {4'h0, r_pos_y[9:6]};
            B_XY2: dbyte = {r_pos_y[5:0], r_pos_x[9:8]};
            B_X3:  dbyte = r_pos_x[7:0];
            B_TB6: dbyte = {2'b00, r_btn[5:4], 1'b0, r_btn[2:0]};
            B_LG1: begin
                if (r_type == REQ_LIGHTGUN) begin
                    dbyte = {trig, 3'b000, r_btn[1], 2'b00, aim[16]};
                end else begin
                    dbyte = {r_btn[0], r_btn[1], r_btn[2], r_btn[3], r_away, 2'b00,
                             aim[16]};
                end
            end
            B_LG2: dbyte = aim[15:8];
            B_LG3: dbyte = aim[7:0];
            default: dbyte = 8'h00;
        endcase
    end

    // Aim unit stage strobes.
    always_comb begin
        aim_ctl = '0;
        if (r_state == ST_RUN && uw.kind == K_AIM) begin
            case (uw.stage)
                AS_SCALE: aim_ctl.scale = 1'b1;
                AS_SUM:   aim_ctl.sum   = 1'b1;
                AS_MUL:   aim_ctl.mul   = 1'b1;
                AS_FIX:   aim_ctl.fix   = 1'b1;
                default:  aim_ctl       = '0;
            endcase
        end
    end

    // Sequencer: executes one control word per cycle, stalls on a busy output.
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_pcnt      = r_pcnt;
        n_wp        = r_wp;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_pos   = r_out_pos;
        n_out_last  = r_out_last;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_step  = entry(t_req'(i_s_tuser));
                    n_pcnt  = 3'd0;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                case (uw.kind)
                    K_CHECK: begin
                        if (fits) begin
                            n_step = r_step + STEP_W'(1);
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                    K_AIM: begin
                        n_step = r_step + STEP_W'(1);
                    end
                    K_EMIT: begin
                        if (out_free) begin
                            n_out_valid = 1'b1;
                            n_out_byte  = dbyte;
                            n_out_pos   = r_wp[7:0];
                            n_out_last  = uw.last;
                            n_wp        = wp_inc;
                            if (uw.last) begin
                                n_state = ST_IDLE;
                            end else begin
                                n_step = r_step + STEP_W'(1);
                            end
                        end
                    end
                    K_PAD: begin
                        if (!room) begin
                            n_state = ST_IDLE;
                        end else if (out_free) begin
                            n_out_valid = 1'b1;
                            n_out_byte  = dbyte;
                            n_out_pos   = r_wp[7:0];
                            n_out_last  = pad_last;
                            n_wp        = wp_inc;
                            n_pcnt      = r_pcnt + 3'd1;
                            if (pad_last) begin
                                n_state = ST_IDLE;
                            end
                        end
                    end
                    K_CLEAR: begin
                        n_wp    = 9'd0;
                        n_state = ST_IDLE;
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_pcnt      <= '0;
            r_wp        <= '0;
            r_out_valid <= 1'b0;
            r_out_byte  <= '0;
            r_out_pos   <= '0;
            r_out_last  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_pcnt      <= n_pcnt;
            r_wp        <= n_wp;
            r_out_valid <= n_out_valid;
            r_out_byte  <= n_out_byte;
            r_out_pos   <= n_out_pos;
            r_out_last  <= n_out_last;
        end
    end

    // Report capture on an input transfer.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_type  <= t_req'(i_s_tuser);
            r_btn   <= i_s_tdata[11:0];
            r_pos_x <= i_s_tdata[27:12];
            r_pos_y <= i_s_tdata[43:28];
            r_pos_z <= i_s_tdata[59:44];
            r_away  <= i_s_tdata[60];
        end
    end

    cppb_aim u_aim (
        .i_clk   (i_clk),
        .i_ctl   (aim_ctl),
        .i_pos_x (r_pos_x),
        .i_pos_y (r_pos_y),
        .i_away  (r_away),
        .o_aim   (aim)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_pos, r_out_byte};
    assign o_m_tlast  = r_out_last;

endmodule
